>>> hw/rtl/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg: shared types and constants for the IMU scale and tilt unit
// Fixed-point widths, CORDIC step table and angle constants.
// ----------------------------------------------------------------------------
`default_nettype none

package isc_pkg;

	// CORDIC operand input width: raw word times 256, one bit for negation
	localparam int unsigned OP_W   = 25;
	// CORDIC x/y datapath width, holds the gain growth without overflow
	localparam int unsigned CW     = 28;
	// angle accumulator width, degrees times 65536
	localparam int unsigned ZW     = 28;
	// square-root radicand and root widths
	localparam int unsigned RAD_W  = 48;
	localparam int unsigned ROOT_W = 24;
	localparam int unsigned TBL_N  = 24;

	localparam logic signed [ZW-1:0] Z90  = ZW'(90 * 65536);
	localparam logic signed [ZW-1:0] Z180 = ZW'(180 * 65536);

	// atan(2^-i) in degrees times 65536, rounded to nearest
	localparam logic [21:0] STEP_ANGLE [TBL_N] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
		22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
		22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
	};

endpackage

`default_nettype wire

>>> hw/rtl/isc_delay.sv
// ----------------------------------------------------------------------------
// isc_delay: enabled alignment delay line
// Carries side-band payload alongside the long arithmetic paths.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_delay #(
	parameter int unsigned W = 16,
	parameter int unsigned D = 4
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] din,
	output logic      [W-1:0] dout
);

	logic [W-1:0] tap_s [D];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < int'(D); i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign dout = tap_s[D-1];

endmodule

`default_nettype wire

>>> hw/rtl/isc_cdiv.sv
// ----------------------------------------------------------------------------
// isc_cdiv: scale by K/D, round to nearest, add offset
// Reciprocal multiply with a single remainder correction, four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_cdiv #(
	parameter int unsigned IW  = 16,
	parameter int unsigned K   = 64,
	parameter int unsigned D   = 131,
	parameter int          OFS = 0,
	parameter int unsigned OW  = 15
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [IW-1:0] x_in,
	output logic signed      [OW-1:0] q_out
);

	localparam int unsigned NW   = IW + $clog2(K) + 2;
	localparam int unsigned D2   = 2 * D;
	localparam logic [31:0] MUL  = 32'((64'd1 << 32) / D2);

	logic signed [IW:0]   ext;
	logic        [IW:0]   absx;
	logic        [NW+31:0] prod;
	logic        [NW-1:0] rem;

	logic                 neg_s1, neg_s2, neg_s3;
	logic        [NW-1:0] n_s1, n_s2;
	logic        [NW-1:0] q0_s2, q_s3;

	assign ext  = (IW+1)'(x_in);
	assign absx = ext[IW] ? (IW+1)'(-ext) : (IW+1)'(ext);
	assign prod = (NW+32)'(n_s1) * (NW+32)'(MUL);
	assign rem  = n_s2 - NW'(q0_s2 * NW'(D2));

	always_ff @(posedge clk) begin
		if (en) begin
			// 2*|x|*K + D, later floor-divided by 2*D
			neg_s1 <= ext[IW];
			n_s1   <= NW'(absx) * NW'(2 * K) + NW'(D);
			neg_s2 <= neg_s1;
			n_s2   <= n_s1;
			q0_s2  <= prod[NW+31:32];
			neg_s3 <= neg_s2;
			q_s3   <= q0_s2 + NW'(rem >= NW'(D2));
			q_out  <= neg_s3 ? OW'(OFS) - OW'(q_s3) : OW'(OFS) + OW'(q_s3);
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/isc_isqrt.sv
// ----------------------------------------------------------------------------
// isc_isqrt: pipelined integer square root
// Restoring digit recurrence, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_isqrt
	import isc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [RAD_W-1:0]  rad,
	output logic      [ROOT_W-1:0] root
);

	localparam int unsigned RMW = ROOT_W + 2;

	logic [RMW-1:0]    rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0] root_s [ROOT_W+1];
	logic [RAD_W-1:0]  rest_s [ROOT_W+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rest_s[0] = rad;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
		logic [RMW:0] rem2;
		logic [RMW:0] trial;

		assign rem2  = {rem_s[k][RMW-2:0], rest_s[k][RAD_W-1 -: 2]};
		assign trial = (RMW+1)'({root_s[k], 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				rest_s[k+1] <= rest_s[k] << 2;
				if (rem2 >= trial) begin
					rem_s[k+1]  <= RMW'(rem2 - trial);
					root_s[k+1] <= {root_s[k][ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k+1]  <= RMW'(rem2);
					root_s[k+1] <= {root_s[k][ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[ROOT_W];

endmodule

`default_nettype wire

>>> hw/rtl/isc_cordic.sv
// ----------------------------------------------------------------------------
// isc_cordic: pipelined CORDIC vectoring atan2 in hundredths of a degree
// Half-plane fold, one rotation per stage, then scale, round and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_cordic
	import isc_pkg::*;
#(
	parameter int unsigned STEPS = 16,
	parameter int          LIMIT = 18000,
	parameter int unsigned OW    = 16
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic signed [OP_W-1:0] y_in,
	input  wire logic signed [OP_W-1:0] x_in,
	output logic signed      [OW-1:0]   angle
);

	logic signed [CW-1:0] x_s [STEPS+1];
	logic signed [CW-1:0] y_s [STEPS+1];
	logic signed [ZW-1:0] z_s [STEPS+1];
	logic                 fix_s [STEPS+1];

	logic signed [CW-1:0] xe, ye, xp, yp;
	logic signed [ZW-1:0] zp;
	logic                 fixp;

	assign xe = CW'(x_in);
	assign ye = CW'(y_in);

	always_comb begin
		xp   = xe;
		yp   = ye;
		zp   = '0;
		fixp = 1'b0;
		priority if (y_in == '0) begin
			fixp = 1'b1;
			zp   = x_in[OP_W-1] ? Z180 : '0;
		end else if (x_in == '0) begin
			fixp = 1'b1;
			zp   = y_in[OP_W-1] ? -Z90 : Z90;
		end else if (x_in[OP_W-1]) begin
			// fold the left half plane by a half turn
			xp = -xe;
			yp = -ye;
			zp = y_in[OP_W-1] ? -Z180 : Z180;
		end else begin
			zp = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= xp;
			y_s[0]   <= yp;
			z_s[0]   <= zp;
			fix_s[0] <= fixp;
		end
	end

	for (genvar i = 0; i < STEPS && i < TBL_N; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				fix_s[i+1] <= fix_s[i];
				if (fix_s[i]) begin
					x_s[i+1] <= x_s[i];
					y_s[i+1] <= y_s[i];
					z_s[i+1] <= z_s[i];
				end else if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + ZW'(STEP_ANGLE[i]);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - ZW'(STEP_ANGLE[i]);
				end
			end
		end
	end

	// degrees*65536 to hundredths: *100, round halves away from zero, clamp
	localparam int unsigned PW = ZW + 8;
	localparam int unsigned AW = 21;

	logic signed [PW-1:0] prod_s1;
	logic                 neg_s2;
	logic signed [AW-1:0] mag_s2;
	logic signed [PW-1:0] zext, pabs;
	logic signed [AW-1:0] h;

	assign zext = PW'(z_s[STEPS]);
	assign pabs = prod_s1[PW-1] ? -prod_s1 : prod_s1;
	assign h    = neg_s2 ? -mag_s2 : mag_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(zext * PW'(100));
			neg_s2  <= prod_s1[PW-1];
			mag_s2  <= AW'((pabs + PW'(32768)) >>> 16);
			priority if (h > AW'(LIMIT)) begin
				angle <= OW'(LIMIT);
			end else if (h < -AW'(LIMIT)) begin
				angle <= OW'(-LIMIT);
			end else begin
				angle <= OW'(h);
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/imu_sample_scale_and_tilt_unit.sv
// Throughput: one sample set per cycle unless the output stalls; the pitch path (square sum, 24-stage
// square root, CORDIC) sets the depth, all other fields are delay-aligned to it.
// A stalled output freezes the whole pipeline; input is taken whenever it moves.
// Reset (arst_n low) clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// imu_sample_scale_and_tilt_unit: IMU sample scaling and accelerometer tilt
// Gyro and temperature scaling, roll and pitch by pipelined CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module imu_sample_scale_and_tilt_unit
	import isc_pkg::*;
#(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// accel_x_raw, accel_y_raw, accel_z_raw, temp_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
	input  wire logic [111:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// accel_x_g, accel_y_g, accel_z_g, rate_x, rate_y, rate_z, temperature,
	// roll_angle, pitch_angle, 5 zero bits
	output logic [143:0]      m_tdata
);

	localparam int unsigned LAT_SQ   = 2 + ROOT_W;
	localparam int unsigned LAT_CORD = CORDIC_STEPS + 4;
	localparam int unsigned LAT      = LAT_SQ + LAT_CORD;
	localparam int unsigned LAT_DIV  = 4;

	logic en;
	logic [LAT-1:0] vld_q;

	logic signed [15:0] ax, ay, az, tr, gx, gy, gz;
	assign {gz, gy, gx, tr, az, ay, ax} = s_tdata;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// gyro and temperature
	logic signed [14:0] rx, ry, rz, tc;
	isc_cdiv #(.IW(16), .K(64), .D(131), .OFS(0),    .OW(15)) u_gx (.clk, .en, .x_in(gx), .q_out(rx));
	isc_cdiv #(.IW(16), .K(64), .D(131), .OFS(0),    .OW(15)) u_gy (.clk, .en, .x_in(gy), .q_out(ry));
	isc_cdiv #(.IW(16), .K(64), .D(131), .OFS(0),    .OW(15)) u_gz (.clk, .en, .x_in(gz), .q_out(rz));
	isc_cdiv #(.IW(16), .K(5),  .D(17),  .OFS(3653), .OW(15)) u_tc (.clk, .en, .x_in(tr), .q_out(tc));

	logic [59:0] scl_d;
	isc_delay #(.W(60), .D(LAT - LAT_DIV)) u_scl_dly (
		.clk, .en, .din({tc, rz, ry, rx}), .dout(scl_d)
	);

	logic [47:0] acc_d;
	isc_delay #(.W(48), .D(LAT)) u_acc_dly (
		.clk, .en, .din({az, ay, ax}), .dout(acc_d)
	);

	// roll
	logic signed [15:0] roll, roll_d;
	isc_cordic #(.STEPS(CORDIC_STEPS), .LIMIT(18000), .OW(16)) u_roll (
		.clk, .en,
		.y_in({ay[15], ay, 8'h00}),
		.x_in({az[15], az, 8'h00}),
		.angle(roll)
	);
	isc_delay #(.W(16), .D(LAT_SQ)) u_roll_dly (.clk, .en, .din(roll), .dout(roll_d));

	// pitch: magnitude of (ay, az) with 8 guard bits
	// a full-scale negative word squares to 2^30, so each square needs 31 bits
	logic [30:0] sqy_s1, sqz_s1;
	logic [31:0] ssum_s2;
	logic [ROOT_W-1:0] mag;

	always_ff @(posedge clk) begin
		if (en) begin
			sqy_s1  <= 31'(ay * ay);
			sqz_s1  <= 31'(az * az);
			ssum_s2 <= 32'(sqy_s1) + 32'(sqz_s1);
		end
	end

	isc_isqrt u_sqrt (.clk, .en, .rad({ssum_s2, 16'h0000}), .root(mag));

	logic signed [15:0] ax_d;
	logic signed [16:0] nax;
	isc_delay #(.W(16), .D(LAT_SQ)) u_ax_dly (.clk, .en, .din(ax), .dout(ax_d));
	assign nax = -(17'(ax_d));

	logic signed [14:0] pitch;
	isc_cordic #(.STEPS(CORDIC_STEPS), .LIMIT(9000), .OW(15)) u_pitch (
		.clk, .en,
		.y_in({nax, 8'h00}),
		.x_in({1'b0, mag}),
		.angle(pitch)
	);

	assign m_tdata = {5'b00000, pitch, roll_d, scl_d, acc_d};

endmodule

`default_nettype wire

>>> hw/rtl/isc_checker.sv
// ----------------------------------------------------------------------------
// isc_checker: port-level checks for the IMU scale and tilt unit
// Output field ranges, padding and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module isc_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [143:0] m_tdata
);

	logic signed [15:0] roll;
	logic signed [14:0] pitch;
	assign roll  = m_tdata[123:108];
	assign pitch = m_tdata[138:124];

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[143:139] == 5'b00000)
		else $error("output padding bits not zero");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (roll <= 16'sd18000 && roll >= -16'sd18000))
		else $error("roll out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (pitch <= 15'sd9000 && pitch >= -15'sd9000))
		else $error("pitch out of range");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction changed while stalled");

endmodule

bind imu_sample_scale_and_tilt_unit isc_checker u_isc_checker (.*);

`default_nettype wire
